>>> rtl/dlf_pkg.sv
// shared types, constants and helpers of the dense layer forward block
package dlf_pkg;

	localparam int DATA_W      = 16;
	localparam int MAX_NEURONS = 64;
	localparam int MAX_INPUTS  = 64;
	localparam int FRAC_W      = DATA_W / 2;

	localparam int CFG_W    = 7;
	localparam int CFG_IX_W = 2;
	localparam int IDX_W    = 12;
	localparam int N_W      = $clog2(MAX_NEURONS);
	localparam int J_W      = $clog2(MAX_INPUTS);
	localparam int WMEM_DEPTH = MAX_NEURONS * MAX_INPUTS;
	localparam int WADDR_W  = $clog2(WMEM_DEPTH);
	localparam int PROD_W   = 2 * DATA_W;
	localparam int ACC_W    = PROD_W + J_W;
	localparam int RES_W    = 32;

	// request kinds
	localparam logic [1:0] REQ_WEIGHT = 2'd0;
	localparam logic [1:0] REQ_BIAS   = 2'd1;
	localparam logic [1:0] REQ_ACT    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IX_W-1:0] CFG_NUM_INPUTS  = CFG_IX_W'(0);
	localparam logic [CFG_IX_W-1:0] CFG_NUM_NEURONS = CFG_IX_W'(1);

	typedef struct packed {
		logic [1:0]              req_type;
		logic [IDX_W-1:0]        index;
		logic signed [DATA_W-1:0] value;
	} dlf_req_t;

	typedef struct packed {
		logic [N_W-1:0]          neuron;
		logic signed [RES_W-1:0] pre_activation;
		logic                    last;
	} dlf_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} dlf_state_t;

	// control that travels with each multiply-accumulate beat
	typedef struct packed {
		logic           first;
		logic           last_in;
		logic           last_neuron;
		logic [N_W-1:0] neuron;
	} dlf_tag_t;

	// clamp a register write into 1..max
	function automatic logic [CFG_W-1:0] clamp_cnt(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] max);
		logic [CFG_W-1:0] r;
		begin
			r = v;
			if (v == '0) r = CFG_W'(1);
			else if (v > max) r = max;
			return r;
		end
	endfunction

	// saturate the accumulator into signed 32 bits
	function automatic logic signed [RES_W-1:0] sat_res(input logic signed [ACC_W-1:0] a);
		logic signed [RES_W-1:0] r;
		begin
			if (a > $signed({{(ACC_W-RES_W){1'b0}}, 1'b0, {(RES_W-1){1'b1}}}))
				r = {1'b0, {(RES_W-1){1'b1}}};
			else if (a < $signed({{(ACC_W-RES_W){1'b1}}, 1'b1, {(RES_W-1){1'b0}}}))
				r = {1'b1, {(RES_W-1){1'b0}}};
			else
				r = a[RES_W-1:0];
			return r;
		end
	endfunction

endpackage

>>> rtl/dense_layer_forward.sv
// fully connected layer forward pass, q8.8 in, saturated q16.16 out
//
// usage
//   - command channel: an item is taken on a clock edge with start high and busy
//     low; req_type selects weight load (index = neuron*num_inputs+j), bias load
//     (index = neuron) or one activation of the previous layer, in order
//   - weight and bias loads and all activations but the last of a vector leave
//     busy low
//   - the num_inputs-th activation starts the layer: busy rises and the block
//     runs one multiply-accumulate per cycle over all num_neurons*num_inputs
//     weights, paced by the single read port of the weight memory
//   - each result beat sits on res for one cycle with res_valid high, neuron
//     order, last marks the final neuron; the receiver cannot stall it
//   - a result passes s1, s2, s3 and the result register after its last
//     product is issued; busy drops the cycle after the final beat
//   - configuration: cfg_valid/cfg_ready beats write num_inputs (index 0) or
//     num_neurons (index 1); ready only while idle; a write discards any
//     partly collected activation vector; values are clamped into 1..64
//   - reset: both registers read 64, no activations collected; the memories
//     hold nothing defined until loaded and need no clearing pass
module dense_layer_forward (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  dlf_pkg::dlf_req_t             req,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dlf_pkg::CFG_IX_W-1:0]  cfg_index,
	input  logic [dlf_pkg::CFG_W-1:0]     cfg_data,
	output logic                          res_valid,
	output dlf_pkg::dlf_res_t             res
);
	import dlf_pkg::*;

	localparam logic [CFG_W-1:0] MAX_IN_C = CFG_W'(MAX_INPUTS);
	localparam logic [CFG_W-1:0] MAX_N_C  = CFG_W'(MAX_NEURONS);

	// storage: one write port used only while idle, one read port used only while running
	logic signed [DATA_W-1:0] w_mem [WMEM_DEPTH];
	logic signed [DATA_W-1:0] b_mem [MAX_NEURONS];
	logic signed [DATA_W-1:0] a_mem [MAX_INPUTS];

	dlf_state_t state_q, state_d;

	logic [CFG_W-1:0]   ni_q, nn_q;
	logic [CFG_W-1:0]   rcv_q;
	logic [CFG_W-1:0]   rcv_pos;
	logic [J_W-1:0]     j_q;
	logic [N_W-1:0]     n_q;
	logic [WADDR_W-1:0] waddr_q;

	logic accept, cfg_wr, act_in, vec_done, issue;
	logic last_in_c, last_n_c;
	dlf_tag_t tag_c;

	// pipeline: s1 memory read, s2 product, s3 accumulate, then result register
	logic                     v_s1, v_s2, v_s3;
	dlf_tag_t                 tag_s1, tag_s2, tag_s3;
	logic signed [DATA_W-1:0] w_s1, a_s1, b_s1, b_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_s3;
	logic                     res_valid_q;
	dlf_res_t                 res_q;

	assign accept  = start && !busy;
	assign cfg_wr  = cfg_valid && cfg_ready;
	assign act_in  = accept && (req.req_type == REQ_ACT);
	// a leftover count past num_inputs restarts the vector
	assign rcv_pos = (rcv_q >= ni_q) ? '0 : rcv_q;
	assign vec_done = act_in && ((rcv_pos + CFG_W'(1)) >= ni_q);

	assign last_in_c = ({1'b0, j_q} == (ni_q - CFG_W'(1)));
	assign last_n_c  = ({1'b0, n_q} == (nn_q - CFG_W'(1)));
	assign tag_c = '{first: (j_q == '0), last_in: last_in_c,
		last_neuron: last_n_c, neuron: n_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (vec_done) state_d = ST_RUN;
			ST_RUN:   if (last_in_c && last_n_c) state_d = ST_DRAIN;
			ST_DRAIN: if (res_valid_q && res_q.last) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy  = 1'b1;
		issue = 1'b0;
		unique case (state_q)
			ST_IDLE:  busy = 1'b0;
			ST_RUN:   issue = 1'b1;
			ST_DRAIN: issue = 1'b0;
			default:  busy = 1'b1;
		endcase
	end

	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration and activation bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ni_q  <= MAX_IN_C;
			nn_q  <= MAX_N_C;
			rcv_q <= '0;
		end else begin
			if (cfg_wr && cfg_index == CFG_NUM_INPUTS) begin
				ni_q  <= clamp_cnt(cfg_data, MAX_IN_C);
				rcv_q <= '0;
			end else if (cfg_wr && cfg_index == CFG_NUM_NEURONS) begin
				nn_q  <= clamp_cnt(cfg_data, MAX_N_C);
				rcv_q <= '0;
			end else if (act_in) begin
				rcv_q <= vec_done ? '0 : rcv_pos + CFG_W'(1);
			end
		end
	end

	// sequencer counters: weights of a layer lie contiguous, so one running address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q     <= '0;
			n_q     <= '0;
			waddr_q <= '0;
		end else if (vec_done) begin
			j_q     <= '0;
			n_q     <= '0;
			waddr_q <= '0;
		end else if (issue) begin
			waddr_q <= waddr_q + WADDR_W'(1);
			if (last_in_c) begin
				j_q <= '0;
				n_q <= n_q + N_W'(1);
			end else begin
				j_q <= j_q + J_W'(1);
			end
		end
	end

	// memory writes, only on accepted command beats
	always_ff @(posedge clk) begin
		if (accept && req.req_type == REQ_WEIGHT)
			w_mem[req.index[WADDR_W-1:0]] <= req.value;
		if (accept && req.req_type == REQ_BIAS && req.index[IDX_W-1:N_W] == '0)
			b_mem[req.index[N_W-1:0]] <= req.value;
		if (act_in)
			a_mem[rcv_pos[J_W-1:0]] <= req.value;
	end

	// memory reads, registered
	always_ff @(posedge clk) begin
		w_s1 <= w_mem[waddr_q];
		a_s1 <= a_mem[j_q];
		b_s1 <= b_mem[n_q];
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			res_valid_q <= v_s3 && tag_s3.last_in;
		end
	end

	// datapath: multiply, then accumulate starting from the shifted bias
	always_ff @(posedge clk) begin
		tag_s1  <= tag_c;
		tag_s2  <= tag_s1;
		b_s2    <= b_s1;
		prod_s2 <= w_s1 * a_s1;
		tag_s3  <= tag_s2;
		if (v_s2) begin
			if (tag_s2.first)
				acc_s3 <= ACC_W'($signed({b_s2, {FRAC_W{1'b0}}})) + ACC_W'(prod_s2);
			else
				acc_s3 <= acc_s3 + ACC_W'(prod_s2);
		end
		res_q.neuron         <= tag_s3.neuron;
		res_q.pre_activation <= sat_res(acc_s3);
		res_q.last           <= tag_s3.last_neuron;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// a result beat only while the layer runs
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> busy)
		else $error("result beat while idle");

	// the layer starts only on the closing activation of a vector
	a_start_act: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && req.req_type == REQ_ACT))
		else $error("busy without a closing activation");

	// the activation count is cleared for the whole run
	a_rcv_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> rcv_q == '0)
		else $error("activation count not cleared while running");

	// the final accumulation of the layer leads to a last beat
	a_last_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && tag_s3.last_in && tag_s3.last_neuron) |=> (res_valid && res.last))
		else $error("last result beat missing");

endmodule

>>> dv/dense_layer_forward_test.sv
// self-checking testbench of the dense layer forward block: directed and random traffic
module dense_layer_forward_test;
	import dlf_pkg::*;

	localparam int CLK_HALF       = 2;
	localparam int RESET_CYCLES   = 11;
	localparam int RANDOM_ITEMS   = 300;
	// the block drops busy the cycle after its last beat, so the settle wait covers it
	localparam int SETTLE_CYCLES  = 8;
	// far beyond the slowest legal silence: one neuron of 64 products plus pipe and sender gap
	localparam int WATCHDOG_LIMIT = 5000;

	// request kind and register indexes that the block has no use for
	localparam logic [1:0]          REQ_UNUSED  = 2'd3;
	localparam logic [CFG_IX_W-1:0] CFG_SPARE_A = CFG_IX_W'(2);
	localparam logic [CFG_IX_W-1:0] CFG_SPARE_B = CFG_IX_W'(3);

	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_REQ,
		OP_REG,
		OP_QUIESCE
	} op_kind_t;

	typedef struct {
		op_kind_t            kind;
		dlf_req_t            req;
		logic [CFG_IX_W-1:0] reg_ix;
		logic [CFG_W-1:0]    reg_val;
	} stim_op_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	logic                busy;
	dlf_req_t            req       = '0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_IX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data  = '0;
	logic                res_valid;
	dlf_res_t            res;

	// shadow of the layer: parameters, collected activations and register values
	logic signed [DATA_W-1:0] w_mem [WMEM_DEPTH];
	logic signed [DATA_W-1:0] b_mem [MAX_NEURONS];
	logic signed [DATA_W-1:0] act_buf [MAX_INPUTS];
	int                       acts_held   = 0;
	logic [CFG_W-1:0]         reg_inputs  = CFG_W'(MAX_INPUTS);
	logic [CFG_W-1:0]         reg_neurons = CFG_W'(MAX_NEURONS);

	dlf_res_t expected_outputs [$];
	stim_op_t op_q [$];

	// beats taken at the last rising edge, read by the driver on the falling edge
	logic req_took = 1'b0;
	logic cfg_took = 1'b0;

	int gap_left    = 0;
	int burst_left  = 1;
	int settle_cnt  = 0;
	int idle_cycles = 0;

	int queued_items = 0;
	int n_items      = 0;
	int n_results    = 0;
	int n_reg_writes = 0;
	int n_saturated  = 0;
	int n_fail       = 0;

	dense_layer_forward u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res       (res)
	);

	always #CLK_HALF clk = ~clk;

	// register values outside 1..top act as the nearest end of the range
	function automatic int clamp_count(input int raw, input int top);
		if (raw < 1)
			return 1;
		if (raw > top)
			return top;
		return raw;
	endfunction

	// fold one accepted request into the shadow; a completed vector yields one result per neuron
	task automatic predict_request(input dlf_req_t r);
		int       ni;
		int       nn;
		int       n;
		int       j;
		longint   acc;
		dlf_res_t e;
		ni = clamp_count(int'(reg_inputs), MAX_INPUTS);
		nn = clamp_count(int'(reg_neurons), MAX_NEURONS);
		case (r.req_type)
			REQ_WEIGHT: begin
				w_mem[r.index] = r.value;
			end
			REQ_BIAS: begin
				// bias addresses past the last neuron are dropped
				if (r.index < MAX_NEURONS)
					b_mem[r.index[N_W-1:0]] = r.value;
			end
			REQ_ACT: begin
				if (acts_held >= ni)
					acts_held = 0;
				act_buf[acts_held] = r.value;
				acts_held++;
				if (acts_held == ni) begin
					acts_held = 0;
					for (n = 0; n < nn; n++) begin
						// bias moves to q16.16, products are exact q16.16
						acc = longint'(b_mem[n]) <<< FRAC_W;
						for (j = 0; j < ni; j++)
							acc += longint'(w_mem[n * ni + j]) * longint'(act_buf[j]);
						e.neuron = N_W'(n);
						e.last   = (n == nn - 1);
						if (acc > 64'sd2147483647) begin
							e.pre_activation = 32'sh7fffffff;
							n_saturated++;
						end else if (acc < -64'sd2147483648) begin
							e.pre_activation = 32'sh80000000;
							n_saturated++;
						end else begin
							e.pre_activation = 32'(acc);
						end
						expected_outputs.push_back(e);
					end
				end
			end
			default: begin
				// unused kind: no effect at all
			end
		endcase
	endtask

	// either register write throws away a partly collected vector; spare indexes do nothing
	task automatic predict_reg_write(input logic [CFG_IX_W-1:0] ix, input logic [CFG_W-1:0] val);
		if (ix == CFG_NUM_INPUTS) begin
			reg_inputs = val;
			acts_held  = 0;
		end else if (ix == CFG_NUM_NEURONS) begin
			reg_neurons = val;
			acts_held   = 0;
		end
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		logic signed [DATA_W-1:0] v;
		v = DATA_W'($urandom);
		case ($urandom_range(0, 9))
			0: v = VAL_MAX;
			1: v = VAL_MIN;
			2: v = '0;
			default: ;
		endcase
		return v;
	endfunction

	task automatic queue_request(input logic [1:0] kind, input logic [IDX_W-1:0] ix,
			input logic signed [DATA_W-1:0] val);
		stim_op_t op;
		op.kind         = OP_REQ;
		op.req.req_type = kind;
		op.req.index    = ix;
		op.req.value    = val;
		op.reg_ix       = '0;
		op.reg_val      = '0;
		op_q.push_back(op);
		queued_items++;
	endtask

	task automatic queue_reg_write(input logic [CFG_IX_W-1:0] ix, input logic [CFG_W-1:0] val);
		stim_op_t op;
		op.kind    = OP_REG;
		op.req     = '0;
		op.reg_ix  = ix;
		op.reg_val = val;
		op_q.push_back(op);
	endtask

	// sender holds off until every expected result is out and the block has gone quiet
	task automatic queue_quiesce();
		stim_op_t op;
		op.kind    = OP_QUIESCE;
		op.req     = '0;
		op.reg_ix  = '0;
		op.reg_val = '0;
		op_q.push_back(op);
	endtask

	// parameter reloads and ignored requests sprinkled between activations
	task automatic queue_noise(input int ni, input int nn);
		case ($urandom_range(0, 5))
			0, 1: queue_request(REQ_WEIGHT,
					IDX_W'($urandom_range(0, nn - 1) * ni + $urandom_range(0, ni - 1)),
					pick_value());
			2: queue_request(REQ_WEIGHT, IDX_W'($urandom), pick_value());
			3: queue_request(REQ_BIAS, IDX_W'($urandom_range(0, nn - 1)), pick_value());
			// mostly past the last neuron, so usually dropped
			4: queue_request(REQ_BIAS, IDX_W'($urandom), pick_value());
			default: queue_request(REQ_UNUSED, IDX_W'($urandom), pick_value());
		endcase
	endtask

	task automatic queue_activations(input int ni, input int nn, input int count,
			input int noise_pct);
		int a;
		for (a = 0; a < count; a++) begin
			if ($urandom_range(0, 99) < noise_pct)
				queue_noise(ni, nn);
			queue_request(REQ_ACT, IDX_W'($urandom), pick_value());
		end
	endtask

	// driver: one beat at a time from op_q, bursts with random gaps, inputs move on the falling edge
	always @(negedge clk) begin : drive
		logic                nxt_start;
		logic                nxt_cfg_valid;
		dlf_req_t            nxt_req;
		logic [CFG_IX_W-1:0] nxt_ix;
		logic [CFG_W-1:0]    nxt_val;
		logic                waiting;
		stim_op_t            op;
		nxt_start     = start;
		nxt_cfg_valid = cfg_valid;
		nxt_req       = req;
		nxt_ix        = cfg_index;
		nxt_val       = cfg_data;
		// a beat still on the wires stays until its handshake
		waiting = (start && !req_took) || (cfg_valid && !cfg_took);
		if (arst_n && !waiting) begin
			nxt_start     = 1'b0;
			nxt_cfg_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (op_q.size() > 0) begin
				op = op_q[0];
				if (op.kind == OP_QUIESCE) begin
					if (expected_outputs.size() != 0) begin
						settle_cnt = 0;
					end else if (settle_cnt < SETTLE_CYCLES) begin
						settle_cnt++;
					end else begin
						settle_cnt = 0;
						void'(op_q.pop_front());
					end
				end else begin
					if (op.kind == OP_REQ) begin
						nxt_start = 1'b1;
						nxt_req   = op.req;
					end else begin
						nxt_cfg_valid = 1'b1;
						nxt_ix        = op.reg_ix;
						nxt_val       = op.reg_val;
					end
					void'(op_q.pop_front());
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						case ($urandom_range(0, 2))
							0: gap_left = 0;
							1: gap_left = $urandom_range(1, 3);
							default: gap_left = $urandom_range(4, 20);
						endcase
					end
				end
			end
		end
		start     <= nxt_start;
		cfg_valid <= nxt_cfg_valid;
		req       <= nxt_req;
		cfg_index <= nxt_ix;
		cfg_data  <= nxt_val;
	end

	// monitor: takes beats on the rising edge, checks results, feeds the shadow, runs the watchdog
	always @(posedge clk) begin : monitor
		dlf_res_t e;
		logic     req_acc;
		logic     cfg_acc;
		if (arst_n) begin
			req_acc = start && !busy;
			cfg_acc = cfg_valid && cfg_ready;
			if (res_valid) begin
				n_results++;
				if (expected_outputs.size() == 0) begin
					$error("result beat for neuron %0d with nothing expected", res.neuron);
					n_fail++;
				end else begin
					e = expected_outputs.pop_front();
					if (res.neuron !== e.neuron) begin
						$error("neuron: expected %0d, got %0d", e.neuron, res.neuron);
						n_fail++;
					end
					if (res.pre_activation !== e.pre_activation) begin
						$error("pre_activation: expected %0d, got %0d",
							e.pre_activation, res.pre_activation);
						n_fail++;
					end
					if (res.last !== e.last) begin
						$error("last: expected %0b, got %0b", e.last, res.last);
						n_fail++;
					end
				end
			end
			// results of this edge are checked before a new vector can add to the queue
			if (req_acc) begin
				predict_request(req);
				n_items++;
			end
			if (cfg_acc) begin
				predict_reg_write(cfg_index, cfg_data);
				n_reg_writes++;
			end
			req_took <= req_acc;
			cfg_took <= cfg_acc;
			if (req_acc || cfg_acc || res_valid)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat in %0d cycles, %0d results still due",
					WATCHDOG_LIMIT, expected_outputs.size());
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int k;
		int ni;
		int nn;
		int raw_ni;
		int raw_nn;
		int nvec;
		int base;
		int w_loaded;

		// opening load: the first 64 weights and every bias; groups of four weights
		// alternate between the most negative and the most positive value
		for (k = 0; k < MAX_INPUTS; k++)
			queue_request(REQ_WEIGHT, IDX_W'(k), ((k / 4) % 2) ? VAL_MAX : VAL_MIN);
		for (k = 0; k < MAX_NEURONS; k++)
			queue_request(REQ_BIAS, IDX_W'(k),
				(k % 3 == 0) ? VAL_MAX : ((k % 3 == 1) ? VAL_MIN : '0));
		w_loaded = MAX_INPUTS;

		// 4 x 16 layer with the most negative activations: every sum runs past 32 bits
		queue_reg_write(CFG_NUM_INPUTS, CFG_W'(4));
		queue_reg_write(CFG_NUM_NEURONS, CFG_W'(16));
		for (k = 0; k < 4; k++)
			queue_request(REQ_ACT, IDX_W'($urandom), VAL_MIN);

		// two activations left over, then a register write must discard them
		queue_request(REQ_ACT, '1, VAL_MAX);
		queue_request(REQ_ACT, '0, VAL_MIN);
		queue_quiesce();
		queue_reg_write(CFG_NUM_INPUTS, CFG_W'(3));
		queue_reg_write(CFG_NUM_NEURONS, CFG_W'(2));
		queue_request(REQ_WEIGHT, '0, 16'sh0100);
		queue_request(REQ_BIAS, IDX_W'(1), 16'sh0080);
		queue_request(REQ_ACT, IDX_W'($urandom), 16'sh0200);
		// unused kind and bias addresses past the last neuron leave everything alone
		queue_request(REQ_UNUSED, '1, VAL_MAX);
		queue_request(REQ_BIAS, IDX_W'(MAX_NEURONS), VAL_MAX);
		queue_request(REQ_BIAS, '1, VAL_MIN);
		queue_request(REQ_ACT, IDX_W'($urandom), VAL_MAX);
		queue_request(REQ_ACT, IDX_W'($urandom), '0);

		// writes to spare register indexes keep a partly collected vector
		queue_request(REQ_ACT, IDX_W'($urandom), 16'sh0180);
		queue_quiesce();
		queue_reg_write(CFG_SPARE_A, CFG_W'(7'h55));
		queue_reg_write(CFG_SPARE_B, CFG_W'(7'h2a));
		queue_request(REQ_ACT, IDX_W'($urandom), 16'shff00);
		queue_request(REQ_ACT, IDX_W'($urandom), VAL_MIN);

		// out-of-range register values: zero acts as one, large acts as the maximum
		queue_quiesce();
		queue_reg_write(CFG_NUM_INPUTS, '0);
		queue_reg_write(CFG_NUM_NEURONS, '1);
		queue_request(REQ_ACT, IDX_W'($urandom), VAL_MAX);
		queue_quiesce();
		queue_reg_write(CFG_NUM_INPUTS, '1);
		queue_reg_write(CFG_NUM_NEURONS, '0);
		queue_activations(MAX_INPUTS, 1, MAX_INPUTS, 0);

		// smallest layer, two vectors back to back
		queue_quiesce();
		queue_reg_write(CFG_NUM_INPUTS, CFG_W'(1));
		queue_reg_write(CFG_NUM_NEURONS, CFG_W'(1));
		queue_request(REQ_ACT, IDX_W'($urandom), VAL_MIN);
		queue_request(REQ_ACT, IDX_W'($urandom), VAL_MAX);
		ni = 1;
		nn = 1;

		// random phases: new sizes, then whole vectors with reloads and noise in between
		base = queued_items;
		while (queued_items - base < RANDOM_ITEMS) begin
			// sometimes leave a partial vector for the next register write to throw away
			if (ni > 1 && $urandom_range(0, 3) == 0)
				queue_activations(ni, nn, $urandom_range(1, ni - 1), 20);
			queue_quiesce();
			// mostly small layers keep the run short; now and then one side goes large
			if ($urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 1) == 0) begin
					ni = $urandom_range(1, MAX_INPUTS);
					nn = $urandom_range(1, 4);
				end else begin
					ni = $urandom_range(1, 4);
					nn = $urandom_range(1, MAX_NEURONS);
				end
			end else begin
				ni = $urandom_range(1, 8);
				nn = $urandom_range(1, 8);
			end
			raw_ni = ni;
			raw_nn = nn;
			if (ni == 1 && $urandom_range(0, 1) == 0)
				raw_ni = 0;
			if (nn == 1 && $urandom_range(0, 1) == 0)
				raw_nn = 0;
			if (ni == MAX_INPUTS && $urandom_range(0, 1) == 0)
				raw_ni = $urandom_range(MAX_INPUTS + 1, 127);
			if (nn == MAX_NEURONS && $urandom_range(0, 1) == 0)
				raw_nn = $urandom_range(MAX_NEURONS + 1, 127);
			if ($urandom_range(0, 1) == 0) begin
				queue_reg_write(CFG_NUM_INPUTS, CFG_W'(raw_ni));
				queue_reg_write(CFG_NUM_NEURONS, CFG_W'(raw_nn));
			end else begin
				queue_reg_write(CFG_NUM_NEURONS, CFG_W'(raw_nn));
				queue_reg_write(CFG_NUM_INPUTS, CFG_W'(raw_ni));
			end
			if ($urandom_range(0, 7) == 0)
				queue_reg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
					CFG_W'($urandom));
			// weights of the new shape that were never loaded come first
			while (w_loaded < ni * nn) begin
				queue_request(REQ_WEIGHT, IDX_W'(w_loaded), pick_value());
				w_loaded++;
			end
			nvec = $urandom_range(1, 4);
			repeat (nvec) begin
				queue_activations(ni, nn, ni, 25);
				if ($urandom_range(0, 5) == 0)
					queue_quiesce();
			end
		end
		queue_quiesce();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// the last op is a quiesce, so an empty op_q means all results are in
		while (op_q.size() != 0 || start || cfg_valid)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_outputs.size() != 0) begin
			$error("%0d expected results never came", expected_outputs.size());
			n_fail++;
		end

		$display("run: %0d requests and %0d register writes taken, %0d results checked",
			n_items, n_reg_writes, n_results);
		$display("run: layers up to 64 inputs or 64 neurons incl. clamped sizes, %0d saturated sums",
			n_saturated);
		if (n_fail == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/dlf_pkg.sv
rtl/dense_layer_forward.sv
dv/dense_layer_forward_test.sv
